FILE: hw/rtl/antialiased_line_stepper_core_assert.svh
// Assertion macros for the antialiased line stepper RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef ANTIALIASED_LINE_STEPPER_CORE_ASSERT_SVH
`define ANTIALIASED_LINE_STEPPER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ALSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");
// next-cycle implication
`define ALSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ALSC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ALSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/alsc_pkg.sv
// Shared types and constants for the antialiased line stepper.
// No dependencies; used by alsc_div and antialiased_line_stepper_core.
`default_nettype none
package alsc_pkg;

	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS = 16;
	localparam int PORT_COORD_W = 12;
	localparam int COV_W = 9;
	localparam logic [COV_W-1:0] COV_FULL = 9'd256;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 72;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_AXIS  = 4'b0010,
		ST_ORDER = 4'b0100,
		ST_DIV   = 4'b1000
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/alsc_div.sv
// Iterative slope divider: one compare-subtract per cycle, yielding an FB+1-bit quotient.
// Uses alsc_pkg for the status struct.
`default_nettype none
module alsc_div #(
	parameter int CB = alsc_pkg::COORD_BITS,
	parameter int FB = alsc_pkg::FRAC_BITS
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire  [CB-1:0]         dividend,
	input  wire  [CB-1:0]         divisor,
	output alsc_pkg::div_stat_t   stat,
	output logic [FB:0]           quotient
);
	localparam int CW = $clog2(FB + 1);

	logic          busy_q;
	logic          done_q;
	logic          first_q;
	logic [CW-1:0] cnt_q;
	logic [CB-1:0] rem_q;
	logic [CB-1:0] div_q;
	logic [FB:0]   quo_q;

	logic [CB:0]   trial;
	logic          ge;
	logic [CB:0]   diff;

	// first iteration yields the integer bit, later ones shift in zeros
	assign trial = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				cnt_q   <= CW'(FB);
			end else if (busy_q) begin
				first_q <= 1'b0;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CB-1:0] : trial[CB-1:0];
			quo_q <= {quo_q[FB-1:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule
`default_nettype wire

FILE: hw/rtl/antialiased_line_stepper_core.sv
// Channel   Dir  Width  Contents
// s_*       in   48+1   line endpoints (tdata), func (tuser)
// m_*       out  72+1+1 pixel pair (tdata), second_valid (tuser), last column (tlast)
//
// Load: accepted, then setup in ST_AXIS and ST_ORDER and the divide in ST_DIV (FB+1
// compare-subtract steps in alsc_div, then the quotient is taken); no minor motion skips the divide.
// Step: one column per accepted step on an active line, taken only while the output register is free or draining.
// s_tready stays low during setup and division. Reset clears the sequencer and line state.
// Top level of the antialiased line stepper; depends on alsc_pkg, alsc_div and the assert header.
`default_nettype none
`include "antialiased_line_stepper_core_assert.svh"
module antialiased_line_stepper_core #(
	parameter int COORD_BITS = alsc_pkg::COORD_BITS,
	parameter int FRAC_BITS  = alsc_pkg::FRAC_BITS
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// start_x, start_y, end_x, end_y (12 bits each, from bit 0 up)
	input  wire  [alsc_pkg::S_TDATA_W-1:0]   s_tdata,
	// func
	input  wire                              s_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// first_px_x, first_px_y, first_coverage, second_px_x, second_px_y,
	// second_coverage, zero fill (from bit 0 up)
	output logic [alsc_pkg::M_TDATA_W-1:0]   m_tdata,
	// second_valid
	output logic                             m_tuser,
	output logic                             m_tlast
);
	localparam int CB = COORD_BITS;
	localparam int FB = FRAC_BITS;
	localparam int EW = CB + FB;
	localparam int PW = alsc_pkg::PORT_COORD_W;
	localparam int CW = alsc_pkg::COV_W;
	localparam logic [EW-1:0] ERR_MAX = {EW{1'b1}};

	alsc_pkg::state_t state_q;

	logic [CB-1:0] ax_q, ay_q, bx_q, by_q;
	logic [CB-1:0] amaj_q, amin_q, bmaj_q, bmin_q;
	logic          steep_q, falling_q, flat_q, active_q;
	logic [CB-1:0] cur_q, end_q;
	logic [EW-1:0] err_q;
	logic [FB:0]   slope_q;

	logic          m_tvalid_q, m_tuser_q, m_tlast_q;
	logic [alsc_pkg::M_TDATA_W-1:0] m_tdata_q;

	logic s_fire, load_fire, step_fire;

	assign s_tready  = (state_q == alsc_pkg::ST_IDLE) && (!m_tvalid_q || m_tready);
	assign s_fire    = s_tvalid && s_tready;
	assign load_fire = s_fire && (s_tuser == alsc_pkg::FUNC_LOAD);
	assign step_fire = s_fire && (s_tuser == alsc_pkg::FUNC_STEP) && active_q;

	// axis exchange
	logic [CB-1:0] adx, ady;
	logic          steep_c;
	assign adx     = (bx_q > ax_q) ? bx_q - ax_q : ax_q - bx_q;
	assign ady     = (by_q > ay_q) ? by_q - ay_q : ay_q - by_q;
	assign steep_c = ady > adx;

	// endpoint ordering along the major axis
	logic          swap_c;
	logic [CB-1:0] omaj0, omin0, omaj1, omin1, dmaj_c, dmin_c;
	assign swap_c = bmaj_q < amaj_q;
	assign omaj0  = swap_c ? bmaj_q : amaj_q;
	assign omin0  = swap_c ? bmin_q : amin_q;
	assign omaj1  = swap_c ? amaj_q : bmaj_q;
	assign omin1  = swap_c ? amin_q : bmin_q;
	assign dmaj_c = omaj1 - omaj0;
	assign dmin_c = (omin1 > omin0) ? omin1 - omin0 : omin0 - omin1;

	alsc_pkg::div_stat_t div_stat;
	logic                div_start;
	logic [FB:0]         div_quo;
	assign div_start = (state_q == alsc_pkg::ST_ORDER) && (dmin_c != '0);

	alsc_div #(
		.CB(CB),
		.FB(FB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dmin_c),
		.divisor  (dmaj_c),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// column result
	logic [CB-1:0] ip, ip_up, ip_dn, nb_min;
	logic [7:0]    f8;
	logic [CW-1:0] cov_f, cov_r, cov1, cov2;
	logic [PW-1:0] p1x, p1y, p2x, p2y;
	logic          is_last;
	assign ip      = err_q[EW-1:FB];
	assign ip_up   = ip + 1'b1;
	assign ip_dn   = ip - 1'b1;
	assign nb_min  = falling_q ? ip_dn : ip_up;
	assign f8      = err_q[FB-1:FB-8];
	assign cov_f   = {1'b0, f8};
	assign cov_r   = alsc_pkg::COV_FULL - cov_f;
	assign is_last = cur_q == end_q;
	assign p1x     = PW'(steep_q ? ip : cur_q);
	assign p1y     = PW'(steep_q ? cur_q : ip);
	assign p2x     = flat_q ? '0 : PW'(steep_q ? nb_min : cur_q);
	assign p2y     = flat_q ? '0 : PW'(steep_q ? cur_q : nb_min);
	assign cov1    = flat_q ? alsc_pkg::COV_FULL : (falling_q ? cov_f : cov_r);
	assign cov2    = flat_q ? '0 : (falling_q ? cov_r : cov_f);

	// saturating error update
	logic [EW:0]   err_sum, err_dif;
	logic [EW-1:0] err_next;
	assign err_sum = {1'b0, err_q} + (EW+1)'(slope_q);
	assign err_dif = {1'b0, err_q} - (EW+1)'(slope_q);
	always_comb begin
		if (falling_q)
			err_next = (err_dif[EW] || err_dif == '0) ? '0 : err_dif[EW-1:0];
		else
			err_next = (err_sum >= {1'b0, ERR_MAX}) ? ERR_MAX : err_sum[EW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= alsc_pkg::ST_IDLE;
			steep_q    <= 1'b0;
			falling_q  <= 1'b0;
			flat_q     <= 1'b0;
			active_q   <= 1'b0;
			cur_q      <= '0;
			end_q      <= '0;
			err_q      <= '0;
			slope_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (step_fire)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				alsc_pkg::ST_IDLE: begin
					if (load_fire) begin
						active_q <= 1'b0;
						state_q  <= alsc_pkg::ST_AXIS;
					end else if (step_fire) begin
						if (is_last) begin
							active_q <= 1'b0;
						end else begin
							cur_q <= cur_q + 1'b1;
							if (!flat_q)
								err_q <= err_next;
						end
					end
				end
				alsc_pkg::ST_AXIS: begin
					steep_q <= steep_c;
					state_q <= alsc_pkg::ST_ORDER;
				end
				alsc_pkg::ST_ORDER: begin
					cur_q     <= omaj0;
					end_q     <= omaj1;
					err_q     <= {omin0, {FB{1'b0}}};
					falling_q <= omin1 < omin0;
					flat_q    <= dmin_c == '0;
					slope_q   <= '0;
					active_q  <= 1'b1;
					state_q   <= (dmin_c == '0) ? alsc_pkg::ST_IDLE : alsc_pkg::ST_DIV;
				end
				alsc_pkg::ST_DIV: begin
					if (div_stat.done) begin
						slope_q <= div_quo;
						state_q <= alsc_pkg::ST_IDLE;
					end
				end
				default: state_q <= alsc_pkg::ST_IDLE;
			endcase
		end
	end

	// payload: raw endpoints, axis-exchanged endpoints, result
	always_ff @(posedge clk) begin
		if (load_fire) begin
			ax_q <= CB'(s_tdata[11:0]);
			ay_q <= CB'(s_tdata[23:12]);
			bx_q <= CB'(s_tdata[35:24]);
			by_q <= CB'(s_tdata[47:36]);
		end
		if (state_q == alsc_pkg::ST_AXIS) begin
			amaj_q <= steep_c ? ay_q : ax_q;
			amin_q <= steep_c ? ax_q : ay_q;
			bmaj_q <= steep_c ? by_q : bx_q;
			bmin_q <= steep_c ? bx_q : by_q;
		end
		if (step_fire) begin
			m_tdata_q <= {6'd0, cov2, p2y, p2x, cov1, p1y, p1x};
			m_tuser_q <= !flat_q;
			m_tlast_q <= is_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	`ALSC_ASSERT_IMPL(a_busy_in_div, clk, arst_n, div_stat.busy, state_q == alsc_pkg::ST_DIV)
	`ALSC_ASSERT_IMPL(a_done_in_div, clk, arst_n, div_stat.done, state_q == alsc_pkg::ST_DIV)
	`ALSC_ASSERT_NEXT(a_last_ends_line, clk, arst_n, step_fire && is_last, !active_q)
	`ALSC_ASSERT_IMPL(a_flat_full_cov, clk, arst_n, m_tvalid_q && !m_tuser_q, m_tdata_q[32:24] == alsc_pkg::COV_FULL && m_tdata_q[65:57] == '0)

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for antialiased_line_stepper_core: line loads and column steps.
// Directed table first, then random line traffic with random gaps and output stalls.
// Depends on alsc_pkg and the core RTL only.
module tb_top;

	localparam int CW = alsc_pkg::PORT_COORD_W;
	localparam int CB = alsc_pkg::COORD_BITS;
	localparam int FB = alsc_pkg::FRAC_BITS;
	localparam int FILL_W = alsc_pkg::M_TDATA_W - 2 * alsc_pkg::COV_W - 4 * CW;
	localparam int ITEM_GOAL = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [CB+FB-1:0] ERR_MAX = '1;

	// result layout: m_tdata from bit 0 up, then m_tuser, then m_tlast
	typedef struct packed {
		logic last_col;
		logic next_on;
		logic [FILL_W-1:0] fill;
		logic [alsc_pkg::COV_W-1:0] next_cov;
		logic [CW-1:0] next_y;
		logic [CW-1:0] next_x;
		logic [alsc_pkg::COV_W-1:0] first_cov;
		logic [CW-1:0] first_y;
		logic [CW-1:0] first_x;
	} column_t;

	typedef enum logic [1:0] {
		CHECK_MODEL,
		CHECK_NONE,
		CHECK_COLUMN
	} row_check_t;

	typedef struct {
		row_check_t how;
		logic func;
		logic [CW-1:0] sx;
		logic [CW-1:0] sy;
		logic [CW-1:0] ex;
		logic [CW-1:0] ey;
		column_t want;
	} stim_row_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [alsc_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = alsc_pkg::FUNC_LOAD;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [alsc_pkg::M_TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	// line state mirrored from the block
	logic ln_steep = 1'b0;
	logic ln_falling = 1'b0;
	logic ln_flat = 1'b0;
	logic ln_active = 1'b0;
	logic [CB-1:0] ln_major = '0;
	logic [CB-1:0] ln_end = '0;
	logic [CB+FB-1:0] ln_err = '0;
	logic [FB:0] ln_slope = '0;

	column_t cols_due[$];
	stim_row_t dir_tab[25];
	int fail_cnt = 0;
	int n_loads = 0;
	int n_cols = 0;
	int n_dead_steps = 0;
	int cyc_cnt = 0;
	int hold_len = 0;
	bit no_gaps = 1'b0;

	antialiased_line_stepper_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Load sets up the line; step emits one column of the active line, if any.
	function automatic bit advance_line(input logic func, input logic [CW-1:0] sx, sy, ex, ey,
			output column_t col);
		logic [CW-1:0] ax, ay, bx, by, t, dmaj, dmin, ip, nb;
		logic [CB+FB-1:0] quo, step_amt;
		logic [7:0] f8;
		logic at_end;
		col = '0;
		if (func == alsc_pkg::FUNC_LOAD) begin
			ax = sx;
			ay = sy;
			bx = ex;
			by = ey;
			ln_steep = ((by > ay) ? by - ay : ay - by) > ((bx > ax) ? bx - ax : ax - bx);
			if (ln_steep) begin
				t = ax; ax = ay; ay = t;
				t = bx; bx = by; by = t;
			end
			// order by the major axis; equal majors keep their order
			if (bx < ax) begin
				t = ax; ax = bx; bx = t;
				t = ay; ay = by; by = t;
			end
			dmaj = bx - ax;
			dmin = (by > ay) ? by - ay : ay - by;
			ln_flat = (dmin == '0);
			ln_falling = (by < ay);
			quo = '0;
			if (dmaj != '0)
				quo = {dmin, {FB{1'b0}}} / {{FB{1'b0}}, dmaj};
			ln_slope = quo[FB:0];
			ln_major = ax;
			ln_end = bx;
			ln_err = {ay, {FB{1'b0}}};
			ln_active = 1'b1;
			return 1'b0;
		end
		if (!ln_active)
			return 1'b0;
		ip = ln_err[CB+FB-1:FB];
		f8 = ln_err[FB-1 -: 8];
		at_end = (ln_major == ln_end);
		col.first_x = ln_steep ? ip : ln_major;
		col.first_y = ln_steep ? ln_major : ip;
		if (ln_flat) begin
			col.first_cov = alsc_pkg::COV_FULL;
		end else begin
			// neighbor wraps around the grid edge
			nb = ln_falling ? ip - 1'b1 : ip + 1'b1;
			col.first_cov = ln_falling ? {1'b0, f8} : alsc_pkg::COV_FULL - {1'b0, f8};
			col.next_cov = ln_falling ? alsc_pkg::COV_FULL - {1'b0, f8} : {1'b0, f8};
			col.next_x = ln_steep ? nb : ln_major;
			col.next_y = ln_steep ? ln_major : nb;
			col.next_on = 1'b1;
		end
		col.last_col = at_end;
		if (at_end) begin
			ln_active = 1'b0;
		end else begin
			ln_major = ln_major + 1'b1;
			step_amt = {{(CB-1){1'b0}}, ln_slope};
			if (!ln_flat) begin
				// saturate at both ends of the error range
				if (ln_falling)
					ln_err = (ln_err > step_amt) ? ln_err - step_amt : '0;
				else
					ln_err = (ERR_MAX - ln_err > step_amt) ? ln_err + step_amt : ERR_MAX;
			end
		end
		return 1'b1;
	endfunction

	function automatic column_t flat_col(input logic [CW-1:0] x, y, input logic at_end);
		column_t c;
		c = '0;
		c.first_x = x;
		c.first_y = y;
		c.first_cov = alsc_pkg::COV_FULL;
		c.last_col = at_end;
		return c;
	endfunction

	task automatic check_field(input string fname, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
			fail_cnt++;
		end
	endtask

	task automatic send_item(input logic func, input logic [CW-1:0] sx, sy, ex, ey,
			input row_check_t how = CHECK_MODEL, input column_t typed = '0);
		int gap;
		bit produced;
		column_t col;
		gap = no_gaps ? 0 : $urandom_range(16, 0);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {ey, ex, sy, sx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		produced = advance_line(func, sx, sy, ex, ey, col);
		case (how)
			CHECK_MODEL: begin
				if (produced)
					cols_due.push_back(col);
			end
			CHECK_COLUMN: cols_due.push_back(typed);
			default: ;
		endcase
		if (func == alsc_pkg::FUNC_LOAD)
			n_loads++;
		else if (produced)
			n_cols++;
		else
			n_dead_steps++;
	endtask

	// Lower valid and hold until every expected column has been seen.
	task automatic drain_pause();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (cols_due.size() != 0) @(posedge clk);
	endtask

	task automatic random_line();
		int sel, len, mn, dmx, dmy, ncol, k;
		logic [CW-1:0] sx, sy, ex, ey, edge_y;
		sel = $urandom_range(99, 0);
		sx = CW'($urandom_range(4095, 0));
		sy = CW'($urandom_range(4095, 0));
		ex = CW'($urandom_range(4095, 0));
		ey = CW'($urandom_range(4095, 0));
		ncol = 0;
		if (sel < 70) begin
			// short complete line, sometimes walked one or two steps past its end
			len = $urandom_range(24, 0);
			mn = $urandom_range(len, 0);
			if ($urandom_range(1, 0) != 0) begin
				dmx = len;
				dmy = mn;
			end else begin
				dmx = mn;
				dmy = len;
			end
			ex = CW'((($urandom_range(1, 0) != 0 && sx >= dmx) || sx + dmx > 4095) ?
					sx - dmx : sx + dmx);
			ey = CW'((($urandom_range(1, 0) != 0 && sy >= dmy) || sy + dmy > 4095) ?
					sy - dmy : sy + dmy);
			ncol = len + 1 + (($urandom_range(3, 0) == 0) ? $urandom_range(2, 1) : 0);
		end else if (sel < 82) begin
			// arbitrary line, cut short by the next load
			ncol = $urandom_range(30, 0);
		end else if (sel < 92) begin
			// diagonal that runs into the top or bottom edge
			len = $urandom_range(12, 1);
			edge_y = ($urandom_range(1, 0) != 0) ? '0 : '1;
			sx = CW'($urandom_range(4095 - len, 0));
			ex = CW'(sx + len);
			ey = edge_y;
			sy = CW'((edge_y == '0) ? len : 4095 - len);
			if ($urandom_range(1, 0) != 0) begin
				{sx, ex} = {ex, sx};
				{sy, ey} = {ey, sy};
			end
			ncol = len + 1;
		end else begin
			// noise: loose items of either kind
			for (k = 0; k < $urandom_range(3, 1); k++)
				send_item($urandom_range(1, 0) != 0 ? alsc_pkg::FUNC_STEP : alsc_pkg::FUNC_LOAD,
						CW'($urandom_range(4095, 0)), CW'($urandom_range(4095, 0)),
						CW'($urandom_range(4095, 0)), CW'($urandom_range(4095, 0)));
			return;
		end
		send_item(alsc_pkg::FUNC_LOAD, sx, sy, ex, ey);
		for (k = 0; k < ncol; k++)
			send_item(alsc_pkg::FUNC_STEP, CW'($urandom_range(4095, 0)),
					CW'($urandom_range(4095, 0)), CW'($urandom_range(4095, 0)),
					CW'($urandom_range(4095, 0)));
	endtask

	// result side: random stall per transfer, long hold when requested
	initial begin
		int stall;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_len != 0) begin
				stall = hold_len;
				hold_len = 0;
			end else begin
				stall = no_gaps ? 0 : $urandom_range(16, 0);
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		column_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tlast, m_tuser, m_tdata};
			if (cols_due.size() == 0) begin
				$display("%0t ns: column with nothing expected, actual %h", $time, got);
				fail_cnt++;
			end else begin
				want = cols_due.pop_front();
				check_field("first_px_x", 32'(want.first_x), 32'(got.first_x));
				check_field("first_px_y", 32'(want.first_y), 32'(got.first_y));
				check_field("first_coverage", 32'(want.first_cov), 32'(got.first_cov));
				check_field("second_px_x", 32'(want.next_x), 32'(got.next_x));
				check_field("second_px_y", 32'(want.next_y), 32'(got.next_y));
				check_field("second_coverage", 32'(want.next_cov), 32'(got.next_cov));
				check_field("tdata fill", 32'(want.fill), 32'(got.fill));
				check_field("second_valid", 32'(want.next_on), 32'(got.next_on));
				check_field("last", 32'(want.last_col), 32'(got.last_col));
			end
		end
	end

	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (cyc_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d columns outstanding", cyc_cnt, cols_due.size());
			$display("[antialiased_line_stepper_core] ERROR");
			$finish;
		end
	end

	initial begin
		int i;
		dir_tab[0] = '{CHECK_NONE, alsc_pkg::FUNC_STEP, '1, '1, '1, '1, '0};
		dir_tab[1] = '{CHECK_MODEL, alsc_pkg::FUNC_LOAD, 12'd7, 12'd7, 12'd7, 12'd7, '0};
		dir_tab[2] = '{CHECK_COLUMN, alsc_pkg::FUNC_STEP, '0, '0, '0, '0,
				flat_col(12'd7, 12'd7, 1'b1)};
		dir_tab[3] = '{CHECK_NONE, alsc_pkg::FUNC_STEP, '1, '1, '1, '1, '0};
		dir_tab[4] = '{CHECK_MODEL, alsc_pkg::FUNC_LOAD, 12'd4095, 12'd0, 12'd0, 12'd0, '0};
		dir_tab[5] = '{CHECK_COLUMN, alsc_pkg::FUNC_STEP, '1, '0, '1, '0,
				flat_col(12'd0, 12'd0, 1'b0)};
		dir_tab[6] = '{CHECK_MODEL, alsc_pkg::FUNC_STEP, '0, '1, '0, '1, '0};
		dir_tab[7] = '{CHECK_MODEL, alsc_pkg::FUNC_LOAD, 12'd4095, 12'd4095, 12'd4095,
				12'd4095, '0};
		dir_tab[8] = '{CHECK_COLUMN, alsc_pkg::FUNC_STEP, '0, '0, '0, '0,
				flat_col(12'd4095, 12'd4095, 1'b1)};
		dir_tab[9] = '{CHECK_MODEL, alsc_pkg::FUNC_LOAD, 12'd0, 12'd4094, 12'd1, 12'd4095, '0};
		dir_tab[10] = '{CHECK_MODEL, alsc_pkg::FUNC_STEP, '0, '0, '0, '0, '0};
		dir_tab[11] = '{CHECK_MODEL, alsc_pkg::FUNC_STEP, '0, '0, '0, '0, '0};
		dir_tab[12] = '{CHECK_MODEL, alsc_pkg::FUNC_LOAD, 12'd1, 12'd0, 12'd0, 12'd1, '0};
		dir_tab[13] = '{CHECK_MODEL, alsc_pkg::FUNC_STEP, '0, '0, '0, '0, '0};
		dir_tab[14] = '{CHECK_MODEL, alsc_pkg::FUNC_STEP, '0, '0, '0, '0, '0};
		dir_tab[15] = '{CHECK_MODEL, alsc_pkg::FUNC_LOAD, 12'd100, 12'd200, 12'd103,
				12'd3000, '0};
		dir_tab[16] = '{CHECK_MODEL, alsc_pkg::FUNC_STEP, '0, '0, '0, '0, '0};
		dir_tab[17] = '{CHECK_MODEL, alsc_pkg::FUNC_STEP, '0, '0, '0, '0, '0};
		dir_tab[18] = '{CHECK_MODEL, alsc_pkg::FUNC_LOAD, 12'd4095, 12'd0, 12'd0, 12'd4095, '0};
		dir_tab[19] = '{CHECK_MODEL, alsc_pkg::FUNC_STEP, '0, '0, '0, '0, '0};
		dir_tab[20] = '{CHECK_MODEL, alsc_pkg::FUNC_LOAD, 12'd2000, 12'd4095, 12'd1990,
				12'd0, '0};
		dir_tab[21] = '{CHECK_MODEL, alsc_pkg::FUNC_STEP, '0, '0, '0, '0, '0};
		dir_tab[22] = '{CHECK_MODEL, alsc_pkg::FUNC_STEP, '0, '0, '0, '0, '0};
		dir_tab[23] = '{CHECK_MODEL, alsc_pkg::FUNC_LOAD, 12'hAAA, 12'h555, 12'h555,
				12'hAAA, '0};
		dir_tab[24] = '{CHECK_MODEL, alsc_pkg::FUNC_STEP, '0, '0, '0, '0, '0};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < 25; i++)
			send_item(dir_tab[i].func, dir_tab[i].sx, dir_tab[i].sy, dir_tab[i].ex, dir_tab[i].ey,
					dir_tab[i].how, dir_tab[i].want);

		while (n_loads + n_cols < 700) random_line();
		// back-to-back stretch on both sides
		no_gaps = 1'b1;
		while (n_loads + n_cols < 1000) random_line();
		no_gaps = 1'b0;

		// stall the output for a long stretch while a long line keeps stepping
		drain_pause();
		hold_len = HOLD_CYCLES;
		no_gaps = 1'b1;
		send_item(alsc_pkg::FUNC_LOAD, 12'd0, CW'($urandom_range(4095, 0)), 12'd4095,
				CW'($urandom_range(4095, 0)));
		repeat (120) send_item(alsc_pkg::FUNC_STEP, CW'($urandom_range(4095, 0)),
				CW'($urandom_range(4095, 0)), CW'($urandom_range(4095, 0)),
				CW'($urandom_range(4095, 0)));
		no_gaps = 1'b0;
		drain_pause();

		while (n_loads + n_cols < ITEM_GOAL) random_line();
		s_tvalid <= 1'b0;
		while (cols_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("run covered %0d line loads and %0d checked columns, %0d steps with no line",
				n_loads, n_cols, n_dead_steps);
		$display("with random gaps, a back-to-back stretch and a %0d-cycle output hold",
				HOLD_CYCLES);
		if (fail_cnt == 0)
			$display("[antialiased_line_stepper_core] OK");
		else
			$display("[antialiased_line_stepper_core] ERROR");
		$finish;
	end
endmodule
